@@ hdl/wppd_pkg.sv @@
// shared types, constants and lfsr functions of the ppdu descrambler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package wppd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITCNT_W  = 14;
    localparam int unsigned POS_W     = 11;
    localparam int unsigned LFSR_W    = 7;
    localparam int unsigned SEED_BITS = 7;
    localparam int unsigned JUMP_MAX  = 64;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef logic [LFSR_W-1:0]   t_lfsr;
    typedef logic [BYTE_W-1:0]   t_byte;
    typedef logic [BITCNT_W-1:0] t_bitcnt;
    typedef logic [POS_W-1:0]    t_pos;

    // byte position and latched bit count in effect for the current item
    typedef struct packed {
        t_pos    pos;
        t_bitcnt pbits;
    } t_ctx;

    // one step of x^7 + x^4 + 1: new stage 0 = stage 6 ^ stage 3
    function automatic t_lfsr lfsr_advance(input t_lfsr l);
        return {l[5:0], l[6] ^ l[3]};
    endfunction

    // advance by a fixed number of steps, flattens to an xor network
    function automatic t_lfsr lfsr_jump(input t_lfsr l, input int unsigned steps);
        t_lfsr s;
        s = l;
        for (int unsigned k = 0; k < JUMP_MAX; k++) begin
            if (k < steps) begin
                s = lfsr_advance(s);
            end
        end
        return s;
    endfunction

endpackage

@@ hdl/wppd_seed_load.sv @@
// seed extraction from the seed byte and fixed-length lfsr jump
// depends on wppd_pkg
`timescale 1ns / 1ps

module wppd_seed_load #(
    parameter int unsigned HEADER_BITS = 24
) (
    input  wppd_pkg::t_byte  i_data_byte,
    input  wppd_pkg::t_ctx   i_ctx,
    output wppd_pkg::t_lfsr  o_lfsr
);

    localparam int unsigned H_OFF = HEADER_BITS % 8;

    logic [wppd_pkg::SEED_BITS-1:0] seed;
    wppd_pkg::t_lfsr                 rev;

    always_comb begin
        seed = '0;
        for (int unsigned k = 0; k < wppd_pkg::SEED_BITS; k++) begin
            // only bits inside this byte and inside the count
            if ((H_OFF + k) < 8) begin
                if ({1'b0, i_ctx.pbits} > 15'(HEADER_BITS + k)) begin
                    seed[k] = i_data_byte[3'(H_OFF + k)];
                end
            end
        end
        if (seed == '0) begin
            seed = 7'd1;
        end
        // seed bit 6 lands in stage 0
        for (int unsigned k = 0; k < wppd_pkg::LFSR_W; k++) begin
            rev[k] = seed[wppd_pkg::LFSR_W-1-k];
        end
        o_lfsr = wppd_pkg::lfsr_jump(rev, HEADER_BITS);
    end

endmodule

@@ hdl/wppd_bit_xform.sv @@
// per-byte descramble over eight stream bits and last-byte flag
// depends on wppd_pkg
`timescale 1ns / 1ps

module wppd_bit_xform #(
    parameter int unsigned HEADER_BITS = 24
) (
    input  wppd_pkg::t_byte  i_data_byte,
    input  wppd_pkg::t_ctx   i_ctx,
    input  wppd_pkg::t_lfsr  i_lfsr,
    output wppd_pkg::t_byte  o_out_byte,
    output logic             o_final_byte,
    output wppd_pkg::t_lfsr  o_lfsr
);

    wppd_pkg::t_bitcnt base;
    wppd_pkg::t_bitcnt g;
    wppd_pkg::t_bitcnt last_bit;
    wppd_pkg::t_lfsr   l;
    wppd_pkg::t_byte   res;

    assign base     = {i_ctx.pos, 3'b000};
    assign last_bit = i_ctx.pbits - 14'd1;

    always_comb begin
        l   = i_lfsr;
        res = '0;
        g   = base;
        for (int unsigned i = 0; i < 8; i++) begin
            g = base + 14'(i);
            if (g < i_ctx.pbits) begin
                if (g >= 14'(HEADER_BITS)) begin
                    res[i] = i_data_byte[i] ^ l[6];
                    l      = wppd_pkg::lfsr_advance(l);
                end else begin
                    res[i] = i_data_byte[i];
                end
            end
        end
    end

    assign o_out_byte   = res;
    assign o_lfsr       = l;
    assign o_final_byte = (i_ctx.pbits != '0) && (i_ctx.pos == last_bit[13:3]);

endmodule

@@ hdl/wlan_ppdu_descrambler_core.sv @@
// top level of the byte-serial 802.11a ppdu descrambler (x^7 + x^4 + 1)
// depends on wppd_pkg, wppd_seed_load, wppd_bit_xform
`timescale 1ns / 1ps

// usage
//   input channel i_in_valid / o_in_ready carries one ppdu byte per item, bit 0
//   earliest; i_first_byte marks byte 0 of a packet and samples i_bit_count
//   output channel o_out_valid / i_out_ready carries one descrambled byte per
//   item plus o_final_byte on the byte holding the last counted bit
//   signal field bits pass unchanged; the seed byte reloads the lfsr and a
//   fixed jump network advances it by HEADER_BITS steps in the same cycle
//   path: an accepted item lands in the input register, and its result is loaded
//   into the output register when the compute stage fires, that is once the
//   output register is free or being drained
//   throughput: one item per cycle unless stalled; the lfsr, position and count
//   registers update in the single compute pass between the two registers
//   a stalled receiver holds the output register; the input register still
//   takes one more item, then o_in_ready drops until the output drains
//   reset clears both valid flags, the lfsr, byte position and latched count;
//   no packet seen yet means every byte comes out zero
module wlan_ppdu_descrambler_core #(
    parameter int unsigned MAX_PPDU_BYTES = 1515,
    parameter int unsigned HEADER_BITS    = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wppd_pkg::t_byte     i_data_byte,
    input  logic                i_first_byte,
    input  wppd_pkg::t_bitcnt   i_bit_count,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wppd_pkg::t_byte     o_out_byte,
    output logic                o_final_byte
);

    localparam int unsigned CAP_BITS = 8 * MAX_PPDU_BYTES;
    localparam int unsigned HDR_POS  = HEADER_BITS / 8;

    localparam wppd_pkg::t_bitcnt CAP = wppd_pkg::BITCNT_W'(CAP_BITS);

    // input register
    logic              r_in_valid;
    wppd_pkg::t_byte   r_data;
    logic              r_first;
    wppd_pkg::t_bitcnt r_cnt;

    // descrambler state
    wppd_pkg::t_lfsr   r_lfsr;
    wppd_pkg::t_pos    r_pos;
    wppd_pkg::t_bitcnt r_pbits;

    // output register
    logic              r_out_valid;
    wppd_pkg::t_byte   r_out_byte;
    logic              r_final;

    logic              fire;
    wppd_pkg::t_ctx    ctx;
    wppd_pkg::t_lfsr   seed_lfsr;
    wppd_pkg::t_lfsr   start_lfsr;
    wppd_pkg::t_lfsr   n_lfsr;
    wppd_pkg::t_byte   n_out_byte;
    logic              n_final;
    wppd_pkg::t_pos    n_pos;

    // compute stage moves when the output register is free or being drained
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // a first byte reloads the count (saturated) and restarts the position
    always_comb begin
        if (r_first) begin
            ctx.pos   = '0;
            ctx.pbits = (r_cnt > CAP) ? CAP : r_cnt;
        end else begin
            ctx.pos   = r_pos;
            ctx.pbits = r_pbits;
        end
    end

    wppd_seed_load #(
        .HEADER_BITS (HEADER_BITS)
    ) u_seed (
        .i_data_byte (r_data),
        .i_ctx       (ctx),
        .o_lfsr      (seed_lfsr)
    );

    // the seed byte starts the lfsr from the freshly loaded seed
    assign start_lfsr = (ctx.pos == wppd_pkg::POS_W'(HDR_POS)) ? seed_lfsr : r_lfsr;

    wppd_bit_xform #(
        .HEADER_BITS (HEADER_BITS)
    ) u_xform (
        .i_data_byte  (r_data),
        .i_ctx        (ctx),
        .i_lfsr       (start_lfsr),
        .o_out_byte   (n_out_byte),
        .o_final_byte (n_final),
        .o_lfsr       (n_lfsr)
    );

    // position saturates on long streams
    assign n_pos = (ctx.pos < wppd_pkg::POS_MAX) ? ctx.pos + 11'd1 : ctx.pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_lfsr      <= '0;
            r_pos       <= '0;
            r_pbits     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_lfsr      <= n_lfsr;
                r_pos       <= n_pos;
                r_pbits     <= ctx.pbits;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data  <= i_data_byte;
            r_first <= i_first_byte;
            r_cnt   <= i_bit_count;
        end
        if (fire) begin
            r_out_byte <= n_out_byte;
            r_final    <= n_final;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_final_byte = r_final;

endmodule

@@ bench/tb.sv @@
// self-checking bench for wlan_ppdu_descrambler_core: directed table, then random packets
// depends on wppd_pkg and the core; holds its own byte-level descrambler predictor
`timescale 1ns / 1ps

module tb;

    localparam int unsigned MAX_PPDU_BYTES = 1515;
    localparam int unsigned HEADER_BITS    = 24;
    localparam int unsigned BITS_CAP       = 8 * MAX_PPDU_BYTES;
    localparam int unsigned PHASE_ITEMS    = 530;
    localparam int unsigned CYCLE_LIMIT    = 600000;

    typedef struct {
        wppd_pkg::t_byte   data;
        logic              first;
        wppd_pkg::t_bitcnt cnt;
        bit                typed;
        wppd_pkg::t_byte   x_byte;
        logic              x_fin;
    } t_dir_row;

    typedef struct {
        wppd_pkg::t_byte ob;
        logic            fin;
    } t_byte_result;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_ready;
    wppd_pkg::t_byte   i_data_byte  = '0;
    logic              i_first_byte = 1'b0;
    wppd_pkg::t_bitcnt i_bit_count  = '0;
    logic              o_out_valid;
    logic              i_out_ready  = 1'b0;
    wppd_pkg::t_byte   o_out_byte;
    logic              o_final_byte;

    // predictor state
    wppd_pkg::t_lfsr   scr_lfsr = '0;
    wppd_pkg::t_pos    scr_pos  = '0;
    wppd_pkg::t_bitcnt scr_bits = '0;

    t_byte_result pending_bytes[$];

    int unsigned snd_idle_pct = 35;
    int unsigned rcv_idle_pct = 48;
    int unsigned rcv_phase_pct = 48;
    int unsigned errors     = 0;
    int unsigned n_sent     = 0;
    int unsigned n_checked  = 0;
    int unsigned n_packets  = 0;
    int unsigned n_final    = 0;
    int unsigned cycles     = 0;

    // directed rows; typed expectations only where obvious
    t_dir_row dir_rows [26] = '{
        // nothing started since reset: all zero, count ignored without first
        '{8'hFF, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        '{8'h5A, 1'b0, 14'h3FFF,  1'b1, 8'h00, 1'b0},
        // zero count
        '{8'hFF, 1'b1, 14'd0,     1'b1, 8'h00, 1'b0},
        '{8'hC3, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        // single bit packet, then past the count
        '{8'hFF, 1'b1, 14'd1,     1'b1, 8'h01, 1'b1},
        '{8'hFF, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        // count ends exactly at the signal field
        '{8'h12, 1'b1, 14'd24,    1'b1, 8'h12, 1'b0},
        '{8'h34, 1'b0, 14'd0,     1'b1, 8'h34, 1'b0},
        '{8'hAB, 1'b0, 14'd0,     1'b1, 8'hAB, 1'b1},
        '{8'hFF, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        // count ends inside the seed bits
        '{8'h00, 1'b1, 14'd27,    1'b1, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 14'd0,     1'b1, 8'hFF, 1'b0},
        '{8'h80, 1'b0, 14'd0,     1'b1, 8'h80, 1'b0},
        '{8'h6D, 1'b0, 14'd0,     1'b0, 8'h00, 1'b0},
        // oversized count saturates; all-zero seed is forced to one
        '{8'hFF, 1'b1, 14'h3FFF,  1'b1, 8'hFF, 1'b0},
        '{8'h00, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        '{8'h55, 1'b0, 14'd0,     1'b1, 8'h55, 1'b0},
        '{8'h00, 1'b0, 14'd0,     1'b0, 8'h00, 1'b0},
        '{8'hFF, 1'b0, 14'd0,     1'b0, 8'h00, 1'b0},
        // restart in mid-packet, then an all-ones seed
        '{8'hE7, 1'b1, 14'd100,   1'b1, 8'hE7, 1'b0},
        '{8'h00, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        '{8'h7F, 1'b1, 14'd100,   1'b1, 8'h7F, 1'b0},
        '{8'h00, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        '{8'h00, 1'b0, 14'd0,     1'b1, 8'h00, 1'b0},
        '{8'h7F, 1'b0, 14'd0,     1'b0, 8'h00, 1'b0},
        '{8'h96, 1'b0, 14'h2AAA,  1'b0, 8'h00, 1'b0}
    };

    wlan_ppdu_descrambler_core #(
        .MAX_PPDU_BYTES (MAX_PPDU_BYTES),
        .HEADER_BITS    (HEADER_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_bit_count  (i_bit_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_final_byte (o_final_byte)
    );

    always #10 i_clk = ~i_clk;

    // x^7 + x^4 + 1, feedback from stages 6 and 3 into stage 0
    function automatic wppd_pkg::t_lfsr scr_shift(input wppd_pkg::t_lfsr l);
        logic fb;
        fb = l[6] ^ l[3];
        return wppd_pkg::t_lfsr'((l << 1) | fb);
    endfunction

    function automatic void descramble_predict(input wppd_pkg::t_byte d, input logic first,
                                               input wppd_pkg::t_bitcnt cnt,
                                               output t_byte_result r);
        int unsigned     base;
        int unsigned     g;
        wppd_pkg::t_lfsr seed;
        wppd_pkg::t_lfsr l;
        if (first) begin
            scr_bits = (cnt > BITS_CAP) ? wppd_pkg::t_bitcnt'(BITS_CAP) : cnt;
            scr_pos  = '0;
        end
        base = int'(scr_pos) * 8;
        // seed byte: reload from in-count seed bits and jump past the signal field
        if (int'(scr_pos) == HEADER_BITS / 8) begin
            seed = '0;
            for (int k = 0; k < wppd_pkg::SEED_BITS; k++) begin
                g = HEADER_BITS + k;
                if (g / 8 == int'(scr_pos) && g < int'(scr_bits))
                    seed[k] = d[g % 8];
            end
            if (seed == '0)
                seed = 7'd1;
            for (int k = 0; k < wppd_pkg::SEED_BITS; k++)
                l[k] = seed[6 - k];
            for (int k = 0; k < HEADER_BITS; k++)
                l = scr_shift(l);
            scr_lfsr = l;
        end
        r.ob = '0;
        for (int i = 0; i < 8; i++) begin
            g = base + i;
            if (g < int'(scr_bits)) begin
                r.ob[i] = d[i];
                if (g >= HEADER_BITS) begin
                    r.ob[i] = d[i] ^ scr_lfsr[6];
                    scr_lfsr = scr_shift(scr_lfsr);
                end
            end
        end
        r.fin = (scr_bits != '0) && (int'(scr_pos) == (int'(scr_bits) - 1) / 8);
        if (scr_pos != wppd_pkg::POS_MAX)
            scr_pos = scr_pos + 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // present one item at the falling edge, hold it until accepted, return at a falling edge
    task automatic put_byte(input wppd_pkg::t_byte d, input logic first,
                            input wppd_pkg::t_bitcnt cnt, input bit typed,
                            input wppd_pkg::t_byte xb, input logic xf);
        t_byte_result r;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= d;
        i_first_byte <= first;
        i_bit_count  <= cnt;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        descramble_predict(d, first, cnt, r);
        if (typed) begin
            r.ob  = xb;
            r.fin = xf;
        end
        pending_bytes.push_back(r);
        n_sent++;
        if (first)
            n_packets++;
        @(negedge i_clk);
    endtask

    // one packet: mostly well formed, some cut short, some stray continuation bytes
    task automatic send_packet(input int unsigned phase_snd);
        int unsigned r;
        int unsigned cnt;
        int unsigned nbytes;
        bit          calm;
        calm = ($urandom_range(0, 5) == 0);
        snd_idle_pct = calm ? 0 : phase_snd;
        rcv_idle_pct = calm ? 0 : rcv_phase_pct;
        r = $urandom_range(0, 99);
        if (r < 90) begin
            if (r < 50)
                cnt = $urandom_range(25, 160);
            else if (r < 65)
                cnt = $urandom_range(0, 40);
            else if (r < 80)
                cnt = $urandom_range(160, 600);
            else
                cnt = $urandom_range(0, 16383);
            nbytes = (cnt + 7) / 8 + $urandom_range(0, 2);
            if (nbytes == 0)
                nbytes = 1;
            if (nbytes > 80 || $urandom_range(0, 9) == 0)
                nbytes = $urandom_range(1, (nbytes > 80) ? 80 : nbytes);
            for (int i = 0; i < nbytes; i++)
                put_byte(wppd_pkg::t_byte'($urandom_range(0, 255)), (i == 0),
                         (i == 0) ? wppd_pkg::t_bitcnt'(cnt) :
                         wppd_pkg::t_bitcnt'($urandom_range(0, 16383)), 1'b0, '0, 1'b0);
        end else begin
            nbytes = $urandom_range(1, 5);
            for (int i = 0; i < nbytes; i++)
                put_byte(wppd_pkg::t_byte'($urandom_range(0, 255)), 1'b0,
                         wppd_pkg::t_bitcnt'($urandom_range(0, 16383)), 1'b0, '0, 1'b0);
        end
    endtask

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);

    // result checker
    always @(posedge i_clk) begin
        t_byte_result x;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h final %0b",
                                          o_out_byte, o_final_byte));
            end else begin
                x = pending_bytes.pop_front();
                n_checked++;
                if (o_out_byte !== x.ob)
                    report_mismatch($sformatf("byte #%0d: out_byte %02h, expected %02h",
                                              n_checked, o_out_byte, x.ob));
                if (o_final_byte !== x.fin)
                    report_mismatch($sformatf("byte #%0d: final_byte %0b, expected %0b",
                                              n_checked, o_final_byte, x.fin));
                if (x.fin)
                    n_final++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycles, pending_bytes.size());
            $display("** wlan_ppdu_descrambler_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int unsigned  phase_start;
        t_byte_result left;
        int unsigned  snd_pct [3] = '{35, 48, 0};
        int unsigned  rcv_pct [3] = '{48, 35, 0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n])
            put_byte(dir_rows[n].data, dir_rows[n].first, dir_rows[n].cnt,
                     dir_rows[n].typed, dir_rows[n].x_byte, dir_rows[n].x_fin);

        for (int p = 0; p < 3; p++) begin
            rcv_phase_pct = rcv_pct[p];
            rcv_idle_pct  = rcv_pct[p];
            snd_idle_pct  = snd_pct[p];
            phase_start = n_sent;
            while (n_sent - phase_start < PHASE_ITEMS)
                send_packet(snd_pct[p]);
        end
        i_in_valid <= 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        while (pending_bytes.size() != 0) begin
            left = pending_bytes.pop_front();
            report_mismatch($sformatf("missing byte, expected %02h", left.ob));
        end

        $display("sent %0d items in %0d packets, checked %0d bytes (%0d last-byte flags)",
                 n_sent, n_packets, n_checked, n_final);
        $display("idle mixes: sender/receiver 35/48, 48/35, none; %0d mismatches", errors);
        if (errors == 0) begin
            $display("** wlan_ppdu_descrambler_core: PASSED **");
        end else begin
            $display("** wlan_ppdu_descrambler_core: FAILED **");
        end
        $finish;
    end

endmodule
